@@ rtl/core/sed_pkg.sv @@
// Shared types and codes of the swing extremum detector.
`default_nettype none

package sed_pkg;

   localparam int unsigned OUT_PRICE_BITS = 32;
   localparam int unsigned KIND_BITS      = 3;
   localparam int unsigned INDEX_BITS     = 32;

   localparam logic [KIND_BITS-1:0] KIND_HIGHER_HIGH = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_LOWER_HIGH  = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_HIGHER_LOW  = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_LOWER_LOW   = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_FLAT        = 3'd4;

   // Verdict of one window cell on the bar it is about to take in.
   typedef struct packed {
      logic high_block;
      logic low_block;
   } sed_block_type;

   // Control flags of the request held between the window and the classifier.
   typedef struct packed {
      logic valid;
      logic is_high;
      logic is_low;
   } sed_flags_type;

endpackage

`default_nettype wire

@@ rtl/core/sed_bar_if.sv @@
// Request channel carrying one price bar.
`default_nettype none

interface sed_bar_if;
   logic        valid;
   logic        ready;
   logic [31:0] bar_high;
   logic [31:0] bar_low;

   modport source (output valid, output bar_high, output bar_low, input ready);
   modport sink   (input valid, input bar_high, input bar_low, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sed_ext_if.sv @@
// Response channel carrying one detected swing extremum.
`default_nettype none

interface sed_ext_if;
   logic        valid;
   logic        ready;
   logic [31:0] extremum_price;
   logic [2:0]  extremum_kind;
   logic [31:0] extremum_bar;

   modport source (output valid, output extremum_price, output extremum_kind,
                   output extremum_bar, input ready);
   modport sink   (input valid, input extremum_price, input extremum_kind,
                   input extremum_bar, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sed_cell.sv @@
// One window cell: holds a bar and judges the bar it takes in against the centre.
`default_nettype none

module sed_cell
   import sed_pkg::*;
#(
   parameter int unsigned PRICE_BITS = 32
) (
   input  wire                   clock,
   input  wire                   shift_en,
   input  wire  [PRICE_BITS-1:0] in_high,
   input  wire  [PRICE_BITS-1:0] in_low,
   input  wire  [PRICE_BITS-1:0] centre_high,
   input  wire  [PRICE_BITS-1:0] centre_low,
   output logic [PRICE_BITS-1:0] out_high,
   output logic [PRICE_BITS-1:0] out_low,
   output sed_block_type         block
);

   logic [PRICE_BITS-1:0] high_ff, high_in;
   logic [PRICE_BITS-1:0] low_ff, low_in;

   always_comb begin
      high_in = high_ff;
      low_in  = low_ff;
      if (shift_en) begin
         high_in = in_high;
         low_in  = in_low;
      end
   end

   always_ff @(posedge clock) begin
      high_ff <= high_in;
      low_ff  <= low_in;
   end

   // The incoming bar is the one this cell holds after the shift, so it is
   // judged against the centre of the shifted window.
   assign block.high_block = (in_high >= centre_high);
   assign block.low_block  = (in_low <= centre_low);

   assign out_high = high_ff;
   assign out_low  = low_ff;

endmodule

`default_nettype wire

@@ rtl/core/sed_classify.sv @@
// Classifies a swing against the previous one and holds the response register.
`default_nettype none

module sed_classify
   import sed_pkg::*;
#(
   parameter int unsigned PRICE_BITS = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire sed_flags_type    s1_flags,
   input  wire  [PRICE_BITS-1:0] s1_price,
   input  wire  [INDEX_BITS-1:0] s1_index,
   output logic                  advance,
   sed_ext_if.source             rsp_chan
);

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [OUT_PRICE_BITS-1:0] price_ff, price_in;
   logic [KIND_BITS-1:0]      kind_ff, kind_in;
   logic [INDEX_BITS-1:0]     index_ff, index_in;
   logic [PRICE_BITS-1:0]     last_price_ff, last_price_in;
   logic                      have_last_ff, have_last_in;
   logic [OUT_PRICE_BITS-1:0] s1_price_out;
   logic                      hit;
   logic [KIND_BITS-1:0]      kind_new;

   generate
      if (PRICE_BITS >= OUT_PRICE_BITS) begin : g_trunc
         assign s1_price_out = s1_price[OUT_PRICE_BITS-1:0];
      end else begin : g_ext
         assign s1_price_out = {{(OUT_PRICE_BITS-PRICE_BITS){1'b0}}, s1_price};
      end
   endgenerate

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign hit     = s1_flags.valid && (s1_flags.is_high || s1_flags.is_low);

   always_comb begin
      if (!have_last_ff) begin
         kind_new = s1_flags.is_high ? KIND_HIGHER_HIGH : KIND_LOWER_LOW;
      end else if (s1_price > last_price_ff) begin
         kind_new = s1_flags.is_high ? KIND_HIGHER_HIGH : KIND_HIGHER_LOW;
      end else if (s1_price < last_price_ff) begin
         kind_new = s1_flags.is_high ? KIND_LOWER_HIGH : KIND_LOWER_LOW;
      end else begin
         kind_new = KIND_FLAT;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      price_in      = price_ff;
      kind_in       = kind_ff;
      index_in      = index_ff;
      last_price_in = last_price_ff;
      have_last_in  = have_last_ff;
      if (advance) begin
         rsp_valid_in = hit;
         if (hit) begin
            price_in      = s1_price_out;
            kind_in       = kind_new;
            index_in      = s1_index;
            last_price_in = s1_price;
            have_last_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         have_last_ff  <= 1'b0;
         last_price_ff <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         have_last_ff  <= have_last_in;
         last_price_ff <= last_price_in;
      end
      price_ff <= price_in;
      kind_ff  <= kind_in;
      index_ff <= index_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.extremum_price = price_ff;
   assign rsp_chan.extremum_kind  = kind_ff;
   assign rsp_chan.extremum_bar   = index_ff;

`ifndef SYNTHESIS
   // A pending response is always the most recent swing.
   a_pending_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (have_last_ff && price_ff == OUT_PRICE_BITS'(last_price_ff)))
      else $error("pending response price differs from last swing price");

   // A swing high never gets a low kind.
   a_high_kind: assert property (@(posedge clock) disable iff (reset)
      (advance && hit && s1_flags.is_high) |=>
         (kind_ff == KIND_HIGHER_HIGH || kind_ff == KIND_LOWER_HIGH || kind_ff == KIND_FLAT))
      else $error("swing high classified with a low kind");

   // The first swing after reset is never flat.
   a_first_not_flat: assert property (@(posedge clock) disable iff (reset)
      (advance && hit && !have_last_ff) |=> (kind_ff != KIND_FLAT))
      else $error("first swing classified as flat");
`endif

endmodule

`default_nettype wire

@@ rtl/core/swing_extremum_detector.sv @@
// A swing is held in the s1 request registers and then in the response register, which
// offers it; throughput is one bar per cycle while no response waits to be taken.
// The window is a shift chain of 2*HALF_WINDOW+1 cells, each comparing its incoming
// bar with the new centre in the accept cycle; the classifier adds one more stage.
// Synchronous reset empties the window count, the bar index and the swing history;
// the first response needs 2*HALF_WINDOW+1 bars after reset.
`default_nettype none

module swing_extremum_detector
   import sed_pkg::*;
#(
   parameter int unsigned HALF_WINDOW = 3,
   parameter int unsigned PRICE_BITS  = 32
) (
   input  wire       clock,
   input  wire       reset,
   sed_bar_if.sink   req_chan,
   sed_ext_if.source rsp_chan
);

   localparam int unsigned WIN_LEN = 2 * HALF_WINDOW + 1;
   localparam int unsigned FILL_W  = $clog2(WIN_LEN + 1);
   localparam logic [FILL_W-1:0]     FILL_FULL = FILL_W'(WIN_LEN);
   localparam logic [INDEX_BITS-1:0] HALF_IDX  = INDEX_BITS'(HALF_WINDOW);

   logic                  advance;
   logic                  accept;
   logic                  full_next;
   logic [PRICE_BITS-1:0] in_high, in_low;
   logic [PRICE_BITS-1:0] centre_high, centre_low;
   logic [PRICE_BITS-1:0] cell_high [WIN_LEN];
   logic [PRICE_BITS-1:0] cell_low  [WIN_LEN];
   sed_block_type         cell_block [WIN_LEN];
   logic [WIN_LEN-1:0]    high_block_vec, low_block_vec;
   logic                  is_high, is_low;

   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [INDEX_BITS-1:0] bars_ff, bars_in;
   sed_flags_type         s1_flags_ff, s1_flags_in;
   logic [PRICE_BITS-1:0] s1_price_ff, s1_price_in;
   logic [INDEX_BITS-1:0] s1_index_ff, s1_index_in;

   generate
      if (PRICE_BITS <= 32) begin : g_in_trunc
         assign in_high = req_chan.bar_high[PRICE_BITS-1:0];
         assign in_low  = req_chan.bar_low[PRICE_BITS-1:0];
      end else begin : g_in_ext
         assign in_high = {{(PRICE_BITS-32){1'b0}}, req_chan.bar_high};
         assign in_low  = {{(PRICE_BITS-32){1'b0}}, req_chan.bar_low};
      end
   endgenerate

   assign accept         = req_chan.valid && advance;
   assign req_chan.ready = advance;

   // After the shift, the centre is the bar now held one cell past the middle.
   assign centre_high = cell_high[HALF_WINDOW+1];
   assign centre_low  = cell_low[HALF_WINDOW+1];

   genvar i;
   generate
      for (i = 0; i < WIN_LEN; i++) begin : g_cell
         logic [PRICE_BITS-1:0] next_high, next_low;
         if (i == WIN_LEN - 1) begin : g_tail
            assign next_high = in_high;
            assign next_low  = in_low;
         end else begin : g_body
            assign next_high = cell_high[i+1];
            assign next_low  = cell_low[i+1];
         end

         sed_cell #(
            .PRICE_BITS (PRICE_BITS)
         ) u_cell (
            .clock       (clock),
            .shift_en    (accept),
            .in_high     (next_high),
            .in_low      (next_low),
            .centre_high (centre_high),
            .centre_low  (centre_low),
            .out_high    (cell_high[i]),
            .out_low     (cell_low[i]),
            .block       (cell_block[i])
         );

         if (i == HALF_WINDOW) begin : g_centre
            assign high_block_vec[i] = 1'b0;
            assign low_block_vec[i]  = 1'b0;
         end else begin : g_side
            assign high_block_vec[i] = cell_block[i].high_block;
            assign low_block_vec[i]  = cell_block[i].low_block;
         end
      end
   endgenerate

   assign is_high   = ~|high_block_vec;
   assign is_low    = ~|low_block_vec;
   assign full_next = (fill_ff >= FILL_FULL - FILL_W'(1));

   always_comb begin
      fill_in     = fill_ff;
      bars_in     = bars_ff;
      s1_flags_in = s1_flags_ff;
      s1_price_in = s1_price_ff;
      s1_index_in = s1_index_ff;
      if (accept) begin
         bars_in = bars_ff + INDEX_BITS'(1);
         if (fill_ff != FILL_FULL) begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
      if (advance) begin
         s1_flags_in.valid   = accept && full_next;
         s1_flags_in.is_high = is_high;
         s1_flags_in.is_low  = is_low;
         s1_price_in         = is_high ? centre_high : centre_low;
         s1_index_in         = bars_ff - HALF_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         bars_ff     <= '0;
         s1_flags_ff <= '0;
      end else begin
         fill_ff     <= fill_in;
         bars_ff     <= bars_in;
         s1_flags_ff <= s1_flags_in;
      end
      s1_price_ff <= s1_price_in;
      s1_index_ff <= s1_index_in;
   end

   sed_classify #(
      .PRICE_BITS (PRICE_BITS)
   ) u_classify (
      .clock    (clock),
      .reset    (reset),
      .s1_flags (s1_flags_ff),
      .s1_price (s1_price_ff),
      .s1_index (s1_index_ff),
      .advance  (advance),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTHESIS
   // A request is only tested once the window is full.
   a_tested_full: assert property (@(posedge clock) disable iff (reset)
      s1_flags_ff.valid |-> (fill_ff == FILL_FULL))
      else $error("window tested before it was full");

   // The request side stalls only behind a waiting response.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid)
      else $error("request side stalled with no response pending");
`endif

endmodule

`default_nettype wire
